[src/qft_pkg.sv]
// ----------------------------------------------------------------------------
// qft_pkg: shared types and constants of the quoted field tokenizer
// Configuration layout, the classified character that passes from the front
// end to the back end, and the limits of a line.
// ----------------------------------------------------------------------------
`default_nettype none

package qft_pkg;

   localparam int LINE_MAX    = 1024;
   localparam int TOKENS_MAX  = 64;

   // Kept characters per line are capped by the line maximum and by the 10-bit offsets.
   localparam int KEEP_CAP    = (LINE_MAX - 1 > 1023) ? 1023 : LINE_MAX - 1;
   localparam int TOK_CAP     = (TOKENS_MAX > 64) ? 64 : TOKENS_MAX;

   localparam int CHAR_W      = 16;
   localparam int POS_W       = 10;
   localparam int NUM_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int LLIM_W      = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CHAR_W-1:0] QUOTE_CHAR = 16'h0022;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_A     = 3'd0,
      CSR_DELIM_B     = 3'd1,
      CSR_DELIM_C     = 3'd2,
      CSR_DELIM_D     = 3'd3,
      CSR_DELIM_COUNT = 3'd4,
      CSR_SKIP_EMPTY  = 3'd5,
      CSR_LINE_LIMIT  = 3'd6,
      CSR_TOKEN_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  delim_a;
      logic [CHAR_W-1:0]  delim_b;
      logic [CHAR_W-1:0]  delim_c;
      logic [CHAR_W-1:0]  delim_d;
      logic [2:0]         delim_count;
      logic               skip_empty;
      logic [LLIM_W-1:0]  line_limit;
      logic [COUNT_W-1:0] token_limit;
   } cfg_type;

   // One character after classification; the code itself is no longer needed.
   typedef struct packed {
      logic is_quote;
      logic is_delim;
      logic line_end;
   } item_type;

endpackage

`default_nettype wire

[src/quoted_field_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_core: delimiter tokenizer with quoted fields
// Characters enter on the req_ stream, one per transfer, with tlast on the
// last character of a line. Each token leaves on the rsp_ stream as start
// offset, length and token number in tdata; tlast marks the result that
// closes the line and tuser flags that tokens past the limit were dropped.
// Every line yields exactly one result with tlast set.
// A character is taken every cycle while the queue has room. It passes the front end's delimiter
// compares into a two-entry queue; the back end applies it to the line state
// in the cycle after its transfer at the earliest and registers any result
// in the output register that drives rsp_tvalid, rsp_tdata, rsp_tlast and rsp_tuser.
// A stalled receiver holds the output register; the queue then fills and
// req_tready drops once it holds two characters.
// Reset clears all line state and loads the register defaults: delimiters
// space and newline, empty tokens kept, full line and token limits.
// The user must write registers over csr_ only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_field_tokenizer_core
   import qft_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [CHAR_W-1:0]      req_tdata,   // [15:0] char_code
   input  wire logic                   req_tlast,   // line_end
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [9:0] token_start, [19:10] token_length,
                                                    // [25:20] token_number, [31:26] zero
   output logic                        rsp_tlast,   // line_done
   output logic                        rsp_tuser    // too_many
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELIM_A:     cfg_in.delim_a     = csr_wdata;
            CSR_DELIM_B:     cfg_in.delim_b     = csr_wdata;
            CSR_DELIM_C:     cfg_in.delim_c     = csr_wdata;
            CSR_DELIM_D:     cfg_in.delim_d     = csr_wdata;
            CSR_DELIM_COUNT: cfg_in.delim_count = csr_wdata[2:0];
            CSR_SKIP_EMPTY:  cfg_in.skip_empty  = csr_wdata[0];
            CSR_LINE_LIMIT:  cfg_in.line_limit  = csr_wdata[LLIM_W-1:0];
            CSR_TOKEN_LIMIT: cfg_in.token_limit = csr_wdata[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_a     <= 16'd32;
         cfg_ff.delim_b     <= 16'd10;
         cfg_ff.delim_c     <= 16'd0;
         cfg_ff.delim_d     <= 16'd0;
         cfg_ff.delim_count <= 3'd2;
         cfg_ff.skip_empty  <= 1'b0;
         cfg_ff.line_limit  <= LLIM_W'(LINE_MAX);
         cfg_ff.token_limit <= COUNT_W'(TOKENS_MAX);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   qft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   qft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[src/qft_front.sv]
// ----------------------------------------------------------------------------
// qft_front: input stage of the quoted field tokenizer
// Accepts characters and classifies each as quote, active delimiter or other.
// ----------------------------------------------------------------------------
`default_nettype none

module qft_front
   import qft_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [CHAR_W-1:0]  req_tdata,   // [15:0] char_code
   input  wire logic               req_tlast,   // line_end
   output logic                    push_valid,
   output item_type                push_item,
   input  wire logic               push_ready
);

   logic is_quote;
   logic match;
   logic seen_ff;
   logic seen_in;

   assign is_quote = (req_tdata == QUOTE_CHAR);

   // A delimiter count above four enables all four registers.
   assign match = ((cfg.delim_count != 3'd0) && (req_tdata == cfg.delim_a)) ||
                  ((cfg.delim_count >= 3'd2) && (req_tdata == cfg.delim_b)) ||
                  ((cfg.delim_count >= 3'd3) && (req_tdata == cfg.delim_c)) ||
                  ((cfg.delim_count >= 3'd4) && (req_tdata == cfg.delim_d));

   assign req_tready          = push_ready;
   assign push_valid          = req_tvalid;
   assign push_item.is_quote  = is_quote;
   // A quote toggles quote mode, so it never acts as a delimiter.
   assign push_item.is_delim  = match && !is_quote;
   assign push_item.line_end  = req_tlast;

   // Tracks whether the current line has had a transfer yet.
   assign seen_in = (req_tvalid && req_tready) ? !req_tlast : seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !seen_ff)
      else $error("line tracking not cleared after line end");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (push_valid && push_ready))
      else $error("accepted character not pushed to queue");

   assert property (@(posedge clock) disable iff (reset)
      push_item.is_delim |-> !push_item.is_quote)
      else $error("quote classified as delimiter");

endmodule

`default_nettype wire

[src/qft_queue.sv]
// ----------------------------------------------------------------------------
// qft_queue: short queue between front and back end
// Holds classified characters so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module qft_queue
   import qft_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_item,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_item
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/qft_back.sv]
// ----------------------------------------------------------------------------
// qft_back: tokenizing back end
// Runs the per-line token state on classified characters and holds one
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qft_back
   import qft_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire item_type               pop_item,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [9:0] token_start, [19:10] token_length,
                                                    // [25:20] token_number, [31:26] zero
   output logic                        rsp_tlast,   // line_done
   output logic                        rsp_tuser    // too_many
);

   logic [POS_W-1:0]   position_ff,    position_in;
   logic [POS_W-1:0]   token_begin_ff, token_begin_in;
   logic               quoted_ff,      quoted_in;
   logic               swq_ff,         swq_in;
   logic [POS_W-1:0]   strip_end_ff,   strip_end_in;
   logic               strip_pend_ff,  strip_pend_in;
   logic [COUNT_W-1:0] token_count_ff, token_count_in;
   logic               overflowed_ff,  overflowed_in;

   logic               out_valid_ff,   out_valid_in;
   logic [POS_W-1:0]   out_start_ff,   out_start_in;
   logic [POS_W-1:0]   out_length_ff,  out_length_in;
   logic [NUM_W-1:0]   out_number_ff,  out_number_in;
   logic               out_last_ff,    out_last_in;
   logic               out_many_ff,    out_many_in;

   logic [POS_W-1:0]   keep;
   logic [LLIM_W-1:0]  limit_m1;
   logic [COUNT_W-1:0] tok_lim;
   logic               step;

   assign limit_m1 = cfg.line_limit - 1'b1;

   always_comb begin
      if ((cfg.line_limit == '0) || (limit_m1 > LLIM_W'(KEEP_CAP))) begin
         keep = POS_W'(KEEP_CAP);
      end else begin
         keep = limit_m1[POS_W-1:0];
      end
      if ((cfg.token_limit == '0) || (cfg.token_limit > COUNT_W'(TOK_CAP))) begin
         tok_lim = COUNT_W'(TOK_CAP);
      end else begin
         tok_lim = cfg.token_limit;
      end
   end

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign step      = pop_valid && pop_ready;

   always_comb begin
      logic             last;
      logic             handled;
      logic             final_done;
      logic             emit_req;
      logic             emit_ok;
      logic [POS_W-1:0] emit_start;
      logic [POS_W-1:0] emit_len;
      logic [POS_W-1:0] pos;

      position_in    = position_ff;
      token_begin_in = token_begin_ff;
      quoted_in      = quoted_ff;
      swq_in         = swq_ff;
      strip_end_in   = strip_end_ff;
      strip_pend_in  = strip_pend_ff;
      token_count_in = token_count_ff;
      overflowed_in  = overflowed_ff;

      out_valid_in   = out_valid_ff && !rsp_tready;
      out_start_in   = out_start_ff;
      out_length_in  = out_length_ff;
      out_number_in  = out_number_ff;
      out_last_in    = out_last_ff;
      out_many_in    = out_many_ff;

      pos        = position_ff;
      last       = 1'b0;
      handled    = 1'b0;
      final_done = 1'b0;
      emit_req   = 1'b0;
      emit_ok    = 1'b0;
      emit_start = '0;
      emit_len   = '0;

      if (step) begin
         // Characters past the kept length only wait for the line end.
         if (pos < keep) begin
            last = pop_item.line_end || (pos + 1'b1 == keep);

            if (strip_pend_ff) begin
               strip_pend_in = 1'b0;
               if (pop_item.is_delim) begin
                  emit_req       = 1'b1;
                  emit_start     = token_begin_ff + 1'b1;
                  emit_len       = strip_end_ff - token_begin_ff - 1'b1;
                  token_begin_in = pos + 1'b1;
                  swq_in         = 1'b0;
                  handled        = 1'b1;
               end
            end

            if (!handled) begin
               if (quoted_ff) begin
                  if (pop_item.is_quote) begin
                     quoted_in = 1'b0;
                     if (swq_ff) begin
                        if (last) begin
                           emit_req   = 1'b1;
                           emit_start = token_begin_ff + 1'b1;
                           emit_len   = pos - token_begin_ff - 1'b1;
                           final_done = 1'b1;
                        end else begin
                           // Strip only if a delimiter follows the closing quote.
                           strip_pend_in = 1'b1;
                           strip_end_in  = pos;
                        end
                     end
                  end
               end else if (pop_item.is_quote) begin
                  quoted_in = 1'b1;
                  if (pos == token_begin_ff) begin
                     swq_in = 1'b1;
                  end
               end else if (pop_item.is_delim) begin
                  if ((pos != token_begin_ff) || !cfg.skip_empty) begin
                     emit_req   = 1'b1;
                     emit_start = token_begin_ff;
                     emit_len   = pos - token_begin_ff;
                  end
                  token_begin_in = pos + 1'b1;
                  swq_in         = 1'b0;
               end
            end

            position_in = pos + 1'b1;
            if (last && !final_done && (position_in != token_begin_in)) begin
               emit_req   = 1'b1;
               emit_start = token_begin_in;
               emit_len   = position_in - token_begin_in;
            end
            if (last) begin
               strip_pend_in = 1'b0;
            end
         end

         if (emit_req) begin
            if (token_count_ff >= tok_lim) begin
               overflowed_in = 1'b1;
            end else begin
               emit_ok        = 1'b1;
               token_count_in = token_count_ff + 1'b1;
            end
         end

         if (emit_ok) begin
            out_valid_in  = 1'b1;
            out_start_in  = emit_start;
            out_length_in = emit_len;
            out_number_in = token_count_ff[NUM_W-1:0];
            out_last_in   = pop_item.line_end;
            out_many_in   = overflowed_in;
         end else if (pop_item.line_end) begin
            // End-of-line marker when no token result is emitted on the last character.
            out_valid_in  = 1'b1;
            out_start_in  = position_in;
            out_length_in = '0;
            out_number_in = (token_count_ff > COUNT_W'(63)) ? {NUM_W{1'b1}}
                                                           : token_count_ff[NUM_W-1:0];
            out_last_in   = 1'b1;
            out_many_in   = overflowed_in;
         end

         if (pop_item.line_end) begin
            position_in    = '0;
            token_begin_in = '0;
            quoted_in      = 1'b0;
            swq_in         = 1'b0;
            strip_end_in   = '0;
            strip_pend_in  = 1'b0;
            token_count_in = '0;
            overflowed_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         token_begin_ff <= '0;
         quoted_ff      <= 1'b0;
         swq_ff         <= 1'b0;
         strip_end_ff   <= '0;
         strip_pend_ff  <= 1'b0;
         token_count_ff <= '0;
         overflowed_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         token_begin_ff <= token_begin_in;
         quoted_ff      <= quoted_in;
         swq_ff         <= swq_in;
         strip_end_ff   <= strip_end_in;
         strip_pend_ff  <= strip_pend_in;
         token_count_ff <= token_count_in;
         overflowed_ff  <= overflowed_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_start_ff  <= out_start_in;
      out_length_ff <= out_length_in;
      out_number_ff <= out_number_in;
      out_last_ff   <= out_last_in;
      out_many_ff   <= out_many_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*POS_W - NUM_W){1'b0}},
                        out_number_ff, out_length_ff, out_start_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_many_ff;

   assert property (@(posedge clock) disable iff (reset)
      (step && pop_item.line_end) |=>
         (position_ff == '0) && (token_count_ff == '0) && !overflowed_ff && !quoted_ff)
      else $error("line state not cleared after line end");

   assert property (@(posedge clock) disable iff (reset)
      (step && pop_item.line_end) |=> (out_valid_ff && out_last_ff))
      else $error("line end produced no closing result");

   assert property (@(posedge clock) disable iff (reset)
      strip_pend_ff |-> (!quoted_ff && swq_ff))
      else $error("strip pending outside a closed quoted token");

   assert property (@(posedge clock) disable iff (reset)
      token_begin_ff <= position_ff)
      else $error("token begins past current position");

endmodule

`default_nettype wire
